// ===== sv/pcs_pkg.sv =====
// Package for the PID speed controller: payload structs, register indexes,
// inter-stage structs and fixed constants. No dependencies.

package pcs_pkg;

  // Request payload
  typedef struct packed {
    logic        [2:0]  motor_index;
    logic signed [15:0] target_speed;
    logic signed [15:0] measured_speed;
  } pcs_in_t;

  // Result payload
  typedef struct packed {
    logic signed [15:0] drive_current;
    logic               at_limit;
  } pcs_out_t;

  // Configuration register set
  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [14:0] integral_limit;
    logic [14:0] curr_limit;
  } pcs_cfg_t;

  // Register indexes
  localparam logic [2:0] RegPropGain  = 3'd0;
  localparam logic [2:0] RegIntegGain = 3'd1;
  localparam logic [2:0] RegDerivGain = 3'd2;
  localparam logic [2:0] RegIntegLim  = 3'd3;
  localparam logic [2:0] RegCurrLim   = 3'd4;

  localparam int unsigned CfgDataW = 16;

  // Reset values
  localparam logic [15:0] PropGainRst  = 16'd3661;
  localparam logic [15:0] IntegGainRst = 16'd212;
  localparam logic [15:0] DerivGainRst = 16'd0;
  localparam logic [14:0] IntegLimRst  = 15'd15000;
  localparam logic [14:0] CurrLimRst   = 15'd15000;

  // Speed error clamp
  localparam logic signed [16:0] ErrMax = 17'sd5000;
  localparam logic signed [16:0] ErrMin = -17'sd5000;

  // Error terms for the multiply stage
  typedef struct packed {
    logic               live;   // motor index in range
    logic signed [13:0] err;
    logic signed [15:0] sum;
    logic signed [14:0] diff;
  } pcs_terms_t;

  // Registered products
  typedef struct packed {
    logic               live;
    logic signed [30:0] p_prod;
    logic signed [32:0] i_prod;
    logic signed [31:0] d_prod;
  } pcs_prods_t;

endpackage

// ===== sv/pcs_cfg_regs.sv =====
// Configuration register bank of the PID speed controller.
// Depends on pcs_pkg.

module pcs_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_wr_en_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [pcs_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output pcs_pkg::pcs_cfg_t               cfg_o
);
  import pcs_pkg::*;

  pcs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        RegPropGain:  cfg_d.prop_gain      = cfg_wdata_i;
        RegIntegGain: cfg_d.integ_gain     = cfg_wdata_i;
        RegDerivGain: cfg_d.deriv_gain     = cfg_wdata_i;
        RegIntegLim:  cfg_d.integral_limit = cfg_wdata_i[14:0];
        RegCurrLim:   cfg_d.curr_limit     = cfg_wdata_i[14:0];
        default:      cfg_d = cfg_q;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= PropGainRst;
      cfg_q.integ_gain     <= IntegGainRst;
      cfg_q.deriv_gain     <= DerivGainRst;
      cfg_q.integral_limit <= IntegLimRst;
      cfg_q.curr_limit     <= CurrLimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/pcs_err_stage.sv =====
// Front of the PID pipeline: request register, per-motor loop state,
// error clamp and integral clamp, and the registered error terms.
// Depends on pcs_pkg.

module pcs_err_stage #(
  parameter int unsigned MOTOR_COUNT = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_stall_o,
  input  pcs_pkg::pcs_in_t     req_i,
  input  logic [14:0]          integral_limit_i,
  output logic                 terms_valid_o,
  input  logic                 terms_stall_i,
  output pcs_pkg::pcs_terms_t  terms_o
);
  import pcs_pkg::*;

  localparam int unsigned SlotW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  logic                req_vld_q;
  pcs_in_t             req_q;
  logic                trm_vld_q;
  pcs_terms_t          trm_q, trm_d;
  logic signed [15:0]  err_sum_q   [MOTOR_COUNT];
  logic signed [13:0]  prior_err_q [MOTOR_COUNT];

  logic                trm_take, req_take, live, upd;
  logic [SlotW-1:0]    slot;
  logic signed [15:0]  sum_old;
  logic signed [13:0]  prior_old;
  logic signed [16:0]  raw_err, err_c, sum_raw, lim;

  assign trm_take    = !trm_vld_q || !terms_stall_i;
  assign req_take    = !req_vld_q || trm_take;
  assign req_stall_o = !req_take;

  assign live = 32'(req_q.motor_index) < MOTOR_COUNT;
  assign slot = SlotW'(req_q.motor_index);
  assign upd  = req_vld_q && trm_take && live;

  always_comb begin
    sum_old   = '0;
    prior_old = '0;
    if (live) begin
      sum_old   = err_sum_q[slot];
      prior_old = prior_err_q[slot];
    end
  end

  always_comb begin
    raw_err = $signed({req_q.target_speed[15], req_q.target_speed})
            - $signed({req_q.measured_speed[15], req_q.measured_speed});
    if (raw_err > ErrMax) begin
      err_c = ErrMax;
    end else if (raw_err < ErrMin) begin
      err_c = ErrMin;
    end else begin
      err_c = raw_err;
    end

    lim     = $signed({2'b00, integral_limit_i});
    sum_raw = $signed({sum_old[15], sum_old}) + err_c;
    if (sum_raw > lim) begin
      sum_raw = lim;
    end else if (sum_raw < -lim) begin
      sum_raw = -lim;
    end

    trm_d.live = live;
    trm_d.err  = err_c[13:0];
    trm_d.sum  = sum_raw[15:0];
    trm_d.diff = $signed({err_c[13], err_c[13:0]}) - $signed({prior_old[13], prior_old});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      trm_vld_q <= 1'b0;
    end else begin
      if (req_take) begin
        req_vld_q <= req_valid_i;
      end
      if (trm_take) begin
        trm_vld_q <= req_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take && req_valid_i) begin
      req_q <= req_i;
    end
    if (trm_take && req_vld_q) begin
      trm_q <= trm_d;
    end
  end

  // Loop state is written as the request leaves, so the next one sees it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        err_sum_q[m]   <= '0;
        prior_err_q[m] <= '0;
      end
    end else if (upd) begin
      err_sum_q[slot]   <= trm_d.sum;
      prior_err_q[slot] <= trm_d.err;
    end
  end

  assign terms_valid_o = trm_vld_q;
  assign terms_o       = trm_q;

endmodule

// ===== sv/pcs_mul_stage.sv =====
// Gain multiply stage: three products of the Q8.8 gains and the error terms, registered.
// Depends on pcs_pkg.

module pcs_mul_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 terms_valid_i,
  output logic                 terms_stall_o,
  input  pcs_pkg::pcs_terms_t  terms_i,
  input  pcs_pkg::pcs_cfg_t    cfg_i,
  output logic                 prods_valid_o,
  input  logic                 prods_stall_i,
  output pcs_pkg::pcs_prods_t  prods_o
);
  import pcs_pkg::*;

  logic        vld_q, take;
  pcs_prods_t  prods_q, prods_d;

  assign take          = !vld_q || !prods_stall_i;
  assign terms_stall_o = !take;

  always_comb begin
    prods_d.live   = terms_i.live;
    prods_d.p_prod = $signed({1'b0, cfg_i.prop_gain})  * terms_i.err;
    prods_d.i_prod = $signed({1'b0, cfg_i.integ_gain}) * terms_i.sum;
    prods_d.d_prod = $signed({1'b0, cfg_i.deriv_gain}) * terms_i.diff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= terms_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && terms_valid_i) begin
      prods_q <= prods_d;
    end
  end

  assign prods_valid_o = vld_q;
  assign prods_o       = prods_q;

endmodule

// ===== sv/pcs_out_stage.sv =====
// Output stage: sums the products, truncates toward zero by 256,
// saturates to the current limit and holds the result register.
// Depends on pcs_pkg.

module pcs_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 prods_valid_i,
  output logic                 prods_stall_o,
  input  pcs_pkg::pcs_prods_t  prods_i,
  input  logic [14:0]          curr_limit_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pcs_pkg::pcs_out_t    out_o
);
  import pcs_pkg::*;

  logic               vld_q, take;
  pcs_out_t           res_q, res_d;
  logic signed [33:0] acc;
  logic        [33:0] mag;
  logic        [25:0] mag_sh;
  logic        [14:0] q_mag;
  logic               neg, sat;

  assign take          = !vld_q || !out_stall_i;
  assign prods_stall_o = !take;

  always_comb begin
    acc = 34'(prods_i.p_prod) + 34'(prods_i.i_prod) + 34'(prods_i.d_prod);
    neg = acc[33];
    mag = neg ? 34'(-acc) : 34'(acc);
    mag_sh = mag[33:8];
    sat = mag_sh > 26'(curr_limit_i);
    q_mag = sat ? curr_limit_i : mag_sh[14:0];

    res_d.drive_current = neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    res_d.at_limit      = sat;
    // Out-of-range motor: zero result
    if (!prods_i.live) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= prods_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && prods_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = res_q;

endmodule

// ===== sv/pid_speed_controller.sv =====
// PID speed controller for several motors: positional PID with error and
// integral clamps. Four-register pipeline. Depends on pcs_pkg and pcs_* stages.
//
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i): motor index, target
//   speed and measured speed. Taken at an edge where valid is high and stall
//   is low.
//   Result channel (out_valid_o / out_stall_i / out_data_o): one result per
//   request, in order: saturated drive current and a limit flag.
//   Configuration: cfg_wr_en_i writes cfg_wdata_i into register cfg_idx_i
//   (0 P gain, 1 I gain, 2 D gain, 3 integral limit, 4 current limit).
//   Write only while the pipeline is empty.
// Path: after the request register, a request passes the terms, products
//   and result registers in that order.
// Throughput: one request per cycle, sustained while the receiver does not
//   stall; a request for a motor may follow the previous one for the same
//   motor directly, as the loop state is updated when a request leaves the first stage.
// Reset: pipeline empties, error sums and prior errors clear, registers
//   take their defaults. A stalled receiver holds the result steady and the
//   stall propagates back stage by stage once the pipeline is full.

module pid_speed_controller #(
  parameter int unsigned MOTOR_COUNT = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pcs_pkg::pcs_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pcs_pkg::pcs_out_t             out_data_o,
  input  logic                          cfg_wr_en_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [pcs_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import pcs_pkg::*;

  pcs_cfg_t    cfg;
  logic        trm_valid, trm_stall, prd_valid, prd_stall;
  pcs_terms_t  trm;
  pcs_prods_t  prd;

  pcs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_en_i (cfg_wr_en_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pcs_err_stage #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_err (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (in_valid_i),
    .req_stall_o      (in_stall_o),
    .req_i            (in_data_i),
    .integral_limit_i (cfg.integral_limit),
    .terms_valid_o    (trm_valid),
    .terms_stall_i    (trm_stall),
    .terms_o          (trm)
  );

  pcs_mul_stage u_mul (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .terms_valid_i (trm_valid),
    .terms_stall_o (trm_stall),
    .terms_i       (trm),
    .cfg_i         (cfg),
    .prods_valid_o (prd_valid),
    .prods_stall_i (prd_stall),
    .prods_o       (prd)
  );

  pcs_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .prods_valid_i   (prd_valid),
    .prods_stall_o   (prd_stall),
    .prods_i         (prd),
    .curr_limit_i    (cfg.curr_limit),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_o           (out_data_o)
  );

endmodule

// ===== bench/pid_speed_controller_tb.sv =====
// Self-checking bench for pid_speed_controller: directed and random speed
// requests over several gain and limit settings. Depends on pcs_pkg and the RTL.

module pid_speed_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;

  localparam int MotorCount = 6;
  localparam int IdlePct    = 23;
  localparam int CycleLimit = 200000;
  localparam int ErrClamp   = 5000;
  localparam int DrainWait  = 8;

  // Tracks per-motor loop state and the drive currents owed by the block
  class speed_loop_board;
    logic [15:0] p_gain, i_gain, d_gain;
    logic [14:0] sum_limit, drive_limit;
    int          err_sum [MotorCount];
    int          last_err [MotorCount];
    pcs_out_t    due_currents[$];
    int          requests, results, saturated, absent, mismatches;

    function new();
      p_gain      = PropGainRst;
      i_gain      = IntegGainRst;
      d_gain      = DerivGainRst;
      sum_limit   = IntegLimRst;
      drive_limit = CurrLimRst;
      foreach (err_sum[m]) begin
        err_sum[m]  = 0;
        last_err[m] = 0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        RegPropGain:  p_gain      = val;
        RegIntegGain: i_gain      = val;
        RegDerivGain: d_gain      = val;
        RegIntegLim:  sum_limit   = val[14:0];
        RegCurrLim:   drive_limit = val[14:0];
        default: ;
      endcase
    endfunction

    function pcs_out_t drive_for(pcs_in_t req);
      pcs_out_t res;
      int       m, err, sum, lim, clim;
      longint   acc, mag;
      logic     neg;
      res = '0;
      m = int'(req.motor_index);
      if (m >= MotorCount) begin
        absent++;
        return res;
      end
      err = int'($signed(req.target_speed)) - int'($signed(req.measured_speed));
      if (err > ErrClamp) err = ErrClamp;
      else if (err < -ErrClamp) err = -ErrClamp;
      lim = int'(sum_limit);
      sum = err_sum[m] + err;
      if (sum > lim) sum = lim;
      else if (sum < -lim) sum = -lim;
      acc = longint'(p_gain) * err + longint'(i_gain) * sum
          + longint'(d_gain) * (err - last_err[m]);
      err_sum[m]  = sum;
      last_err[m] = err;
      neg  = acc < 0;
      mag  = neg ? -acc : acc;
      mag  = mag / 256;  // truncation toward zero on the magnitude
      clim = int'(drive_limit);
      if (mag > clim) begin
        mag = clim;
        res.at_limit = 1'b1;
        saturated++;
      end
      res.drive_current = neg ? -mag[15:0] : mag[15:0];
      return res;
    endfunction

    function void note_request(pcs_in_t req);
      requests++;
      due_currents.push_back(drive_for(req));
    endfunction

    function void check_result(pcs_out_t got);
      pcs_out_t want;
      results++;
      if (due_currents.size() == 0) begin
        $error("result %0d/%0b arrived with no request outstanding",
               got.drive_current, got.at_limit);
        mismatches++;
        return;
      end
      want = due_currents.pop_front();
      if (got.drive_current !== want.drive_current) begin
        $error("drive_current: expected %0d, got %0d",
               want.drive_current, got.drive_current);
        mismatches++;
      end
      if (got.at_limit !== want.at_limit) begin
        $error("at_limit: expected %0b, got %0b", want.at_limit, got.at_limit);
        mismatches++;
      end
    endfunction

    function int pending();
      return due_currents.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pcs_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pcs_out_t            out_data_o;
  logic                cfg_wr_en_i = 1'b0;
  logic [2:0]          cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  speed_loop_board loop = new();
  logic            steady = 1'b0;  // no idling on either side while set
  int              cycle_count = 0;
  int              settings = 1;

  pid_speed_controller #(.MOTOR_COUNT(MotorCount)) dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_wr_en_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) loop.note_request(in_data_i);
      if (out_valid_o && !out_stall_i) loop.check_result(out_data_o);
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= steady ? 1'b0 : ($urandom_range(99) < IdlePct);
  end

  task automatic send_request(input pcs_in_t req);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = req;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
  endtask

  task automatic speed_req(input int m, input int goal, input int meas);
    pcs_in_t req;
    req.motor_index    = m[2:0];
    req.target_speed   = goal[15:0];
    req.measured_speed = meas[15:0];
    send_request(req);
  endtask

  // Wait for the pipeline to empty before any register write
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (loop.pending() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_wr_en_i = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    loop.set_reg(idx, val);
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
  endtask

  task automatic load_gains(input int p, input int i, input int d,
                            input int ilim, input int clim);
    write_reg(RegPropGain, p[15:0]);
    write_reg(RegIntegGain, i[15:0]);
    write_reg(RegDerivGain, d[15:0]);
    write_reg(RegIntegLim, ilim[15:0]);
    write_reg(RegCurrLim, clim[15:0]);
    settings++;
  endtask

  // Mostly tracking requests near the goal, some large steps, some noise
  task automatic random_requests(input int count);
    int m, goal, meas, pick;
    repeat (count) begin
      pick = $urandom_range(99);
      m    = ($urandom_range(99) < 8) ? $urandom_range(7, 6) : $urandom_range(5, 0);
      goal = $signed(16'($urandom));
      if (pick < 60) meas = goal + $urandom_range(400) - 200;
      else if (pick < 80) meas = goal + $urandom_range(12000) - 6000;
      else if (pick < 94) meas = $signed(16'($urandom));
      else begin
        goal = ($urandom_range(1)) ? 32767 : -32768;
        meas = ($urandom_range(1)) ? -goal - 1 : 0;
      end
      speed_req(m, goal, meas);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset gains: error clamp, integral clamp both ways, bad motor indexes
    repeat (4) speed_req(0, 32767, -32768);
    repeat (4) speed_req(1, -32768, 32767);
    speed_req(2, 0, 0);
    speed_req(2, 1, 0);
    speed_req(2, -1, 0);
    speed_req(3, 5000, 0);
    speed_req(3, 5001, 0);
    speed_req(3, -5001, 0);
    speed_req(6, 1234, -1234);
    speed_req(7, -32768, 32767);
    speed_req(5, 100, 50);
    speed_req(5, 100, 50);
    speed_req(4, -7, 9);
    speed_req(5, -32768, -32768);
    speed_req(0, -32768, 32767);
    random_requests(90);
    drain();

    // Top of the gain and integral limit ranges, current limit 16384, back to back with no idling
    steady = 1'b1;
    load_gains(65535, 65535, 65535, 32767, 16384);
    random_requests(90);
    drain();
    steady = 1'b0;

    // Zero integral and current limits
    load_gains(700, 300, 500, 0, 0);
    random_requests(70);
    drain();

    // Tiny gains: most outputs truncate to zero; limit beyond the output range
    load_gains(1, 1, 1, 40, 32767);
    random_requests(80);
    drain();

    load_gains(0, 0, 0, 32767, 16384);
    random_requests(40);
    drain();

    repeat (2) begin
      load_gains($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(32767), $urandom_range(16384));
      random_requests(90);
      drain();
    end

    $display("Checked %0d speed requests across %0d gain/limit settings, %0d results.",
             loop.requests, settings, loop.results);
    $display("%0d results hit the current limit, %0d named a motor that does not exist.",
             loop.saturated, loop.absent);
    if (loop.mismatches == 0 && loop.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
